[hdl/sobel_edge_rgb_stream_unit_defines.svh]
// ---------------------------------------------------------------------------
// Sobel edge RGB stream unit - assertion macros
// Concurrent check macros used by the top-level RTL file; compiled out under
// NO_ASSERTIONS. Clock and reset are taken from the including scope.
// ---------------------------------------------------------------------------
`ifndef SOBEL_EDGE_RGB_STREAM_UNIT_DEFINES_SVH
`define SOBEL_EDGE_RGB_STREAM_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
// condition must never be seen at a clock edge
`define SED_ASSERT_NEVER(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
	else $error("sed: forbidden condition seen");
// antecedent implies consequent in the same cycle
`define SED_ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("sed: implication failed");
`else
`define SED_ASSERT_NEVER(label, cond)
`define SED_ASSERT_IMPLY(label, ante, cons)
`endif
`endif

[hdl/sed_pkg.sv]
// ---------------------------------------------------------------------------
// Sobel edge package
// Request types, configuration codes and the per-channel kernel math.
// ---------------------------------------------------------------------------
package sed_pkg;

	localparam int PIX_W       = 24;
	localparam int CH_W        = 8;
	localparam int ROW_W       = 12;
	localparam int COORD_W     = 12;
	localparam int GRAD_W      = 11;
	localparam int CFG_DATA_W  = 13;
	localparam int CFG_IDX_W   = 1;
	localparam int MAX_WIDTH_DEF = 4096;
	localparam int MAX_HEIGHT  = 4096;
	localparam int MIN_DIM     = 3;
	localparam int RST_WIDTH   = 640;
	localparam int RST_HEIGHT  = 480;

	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'd1;

	localparam logic [CH_W-1:0] SAT_MAX = 8'd255;

	typedef struct packed {
		logic [CH_W-1:0] pixel_red;
		logic [CH_W-1:0] pixel_green;
		logic [CH_W-1:0] pixel_blue;
	} pix_t;

	typedef struct packed {
		logic [CH_W-1:0]    edge_red;
		logic [CH_W-1:0]    edge_green;
		logic [CH_W-1:0]    edge_blue;
		logic [COORD_W-1:0] centre_row;
		logic [COORD_W-1:0] centre_col;
		logic               frame_last;
	} res_t;

	// one column of the 3x3 window, top is the oldest row
	typedef struct packed {
		logic [PIX_W-1:0] top;
		logic [PIX_W-1:0] mid;
		logic [PIX_W-1:0] bot;
	} wcol_t;

	// (p0 + 2*p1 + p2) - (n0 + 2*n1 + n2)
	function automatic logic signed [GRAD_W-1:0] grad(
		input logic [CH_W-1:0] p0, input logic [CH_W-1:0] p1, input logic [CH_W-1:0] p2,
		input logic [CH_W-1:0] n0, input logic [CH_W-1:0] n1, input logic [CH_W-1:0] n2);
		logic [CH_W+1:0] ps;
		logic [CH_W+1:0] ns;
		ps = {2'b00, p0} + {1'b0, p1, 1'b0} + {2'b00, p2};
		ns = {2'b00, n0} + {1'b0, n1, 1'b0} + {2'b00, n2};
		return $signed({1'b0, ps}) - $signed({1'b0, ns});
	endfunction

	// |gx| + |gy|, clipped to 255
	function automatic logic [CH_W-1:0] mag(
		input logic signed [GRAD_W-1:0] gx, input logic signed [GRAD_W-1:0] gy);
		logic [GRAD_W-1:0] ax;
		logic [GRAD_W-1:0] ay;
		logic [GRAD_W:0]   s;
		ax = gx[GRAD_W-1] ? GRAD_W'(-gx) : GRAD_W'(gx);
		ay = gy[GRAD_W-1] ? GRAD_W'(-gy) : GRAD_W'(gy);
		s  = {1'b0, ax} + {1'b0, ay};
		return (s > (GRAD_W+1)'(SAT_MAX)) ? SAT_MAX : s[CH_W-1:0];
	endfunction

endpackage

[hdl/sobel_edge_rgb_stream_unit.sv]
// ---------------------------------------------------------------------------
// Sobel edge RGB stream unit
// Streaming 3x3 Sobel edge detector on 24-bit RGB, L1 magnitude per channel.
// ---------------------------------------------------------------------------
// Usage:
//  - pix_valid/pix_stall/pix carries RGB pixels in raster order, one request
//    per pixel. result_valid/result_stall/result carries one request per
//    interior pixel (row and column both at least 1 and below the last).
//    Border pixels produce nothing; the consumer fills them with zero.
//  - cfg_write/cfg_index/cfg_data set image width and height (clamped to
//    3..MAX_WIDTH and 3..4096). Write them only while the unit is idle.
//  - Sustained rate is one pixel per clock unless the receiver stalls: each
//    pixel costs one read and one write of the line RAM, which has a port for each.
//  - A result passes the s1 registers, the s2 registers and the output
//    register after the pixel completing its 3x3 window is accepted.
//  - Reset clears the pipeline, the row/column counters and restores the
//    default 640x480 geometry. Line RAM contents are not cleared; rows are
//    always written before they are read.
//  - When the receiver stalls, the output register holds; the gradient
//    stage and the line stage still fill, and pix_stall rises only once a
//    result-bearing pixel cannot move on.
// ---------------------------------------------------------------------------
`include "sobel_edge_rgb_stream_unit_defines.svh"

module sobel_edge_rgb_stream_unit #(
	parameter int MAX_WIDTH = sed_pkg::MAX_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write,
	input  logic [sed_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sed_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             pix_valid,
	output logic                             pix_stall,
	input  sed_pkg::pix_t                    pix,
	output logic                             result_valid,
	input  logic                             result_stall,
	output sed_pkg::res_t                    result
);

	localparam int CW    = $clog2(MAX_WIDTH);          // column counter / RAM address
	localparam int DW    = sed_pkg::CFG_DATA_W;
	localparam int CMPW  = (CW + 1 > DW) ? CW + 1 : DW; // width clamp compare
	localparam int RW    = sed_pkg::ROW_W;
	localparam int XW    = sed_pkg::COORD_W;
	localparam int PW    = sed_pkg::PIX_W;
	localparam int GW    = sed_pkg::GRAD_W;
	localparam int KW    = sed_pkg::CH_W;
	localparam int WRST  = (sed_pkg::RST_WIDTH > MAX_WIDTH) ? MAX_WIDTH : sed_pkg::RST_WIDTH;

	// -----------------------------------------------------------------------
	// Geometry: store last column / last row indexes, already clamped
	// -----------------------------------------------------------------------
	logic [CW-1:0]   wlast_q;
	logic [RW-1:0]   hlast_q;
	logic [CMPW-1:0] wcfg;
	logic [CMPW-1:0] wclamp;
	logic [DW-1:0]   hclamp;

	always_comb begin
		wcfg   = CMPW'(cfg_data);
		wclamp = (wcfg < CMPW'(sed_pkg::MIN_DIM)) ? CMPW'(sed_pkg::MIN_DIM) :
		         (wcfg > CMPW'(MAX_WIDTH))        ? CMPW'(MAX_WIDTH) : wcfg;
		hclamp = (cfg_data < DW'(sed_pkg::MIN_DIM))    ? DW'(sed_pkg::MIN_DIM) :
		         (cfg_data > DW'(sed_pkg::MAX_HEIGHT)) ? DW'(sed_pkg::MAX_HEIGHT) : cfg_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlast_q <= CW'(WRST - 1);
			hlast_q <= RW'(sed_pkg::RST_HEIGHT - 1);
		end else if (cfg_write) begin
			unique case (cfg_index)
				sed_pkg::CFG_IMAGE_WIDTH:  wlast_q <= CW'(wclamp - CMPW'(1));
				sed_pkg::CFG_IMAGE_HEIGHT: hlast_q <= RW'(hclamp - DW'(1));
			endcase
		end
	end

	// -----------------------------------------------------------------------
	// Flow control
	// s1: line RAM data back, window shift, RAM write-back, gradients
	// s2: gradients held, magnitudes formed into the output register
	// -----------------------------------------------------------------------
	logic v_s1;
	logic v_s2;
	logic emit_s1;
	logic pix_take;
	logic out_ready;
	logic adv2;
	logic s1_go;

	assign out_ready = !result_valid || !result_stall;
	assign adv2      = !v_s2 || out_ready;
	// non-emitting pixels retire from s1 without waiting on the output
	assign s1_go     = v_s1 && (!emit_s1 || adv2);
	assign pix_stall = v_s1 && !s1_go;
	assign pix_take  = pix_valid && !pix_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			if (pix_take) begin
				v_s1 <= 1'b1;
			end else if (s1_go) begin
				v_s1 <= 1'b0;
			end
			if (s1_go && emit_s1) begin
				v_s2 <= 1'b1;
			end else if (out_ready) begin
				v_s2 <= 1'b0;
			end
			if (v_s2 && out_ready) begin
				result_valid <= 1'b1;
			end else if (!result_stall) begin
				result_valid <= 1'b0;
			end
		end
	end

	// -----------------------------------------------------------------------
	// Raster counters
	// -----------------------------------------------------------------------
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic          col_end;
	logic          row_end;

	assign col_end = col_q >= wlast_q;
	assign row_end = row_q >= hlast_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (pix_take) begin
			if (col_end) begin
				col_q <= '0;
				row_q <= row_end ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// -----------------------------------------------------------------------
	// Stage 1 payload
	// -----------------------------------------------------------------------
	logic [PW-1:0] px_s1;
	logic [CW-1:0] col_s1;
	logic [XW-1:0] crow_s1;
	logic [XW-1:0] ccol_s1;
	logic          last_s1;

	always_ff @(posedge clk) begin
		if (pix_take) begin
			px_s1   <= {pix.pixel_red, pix.pixel_green, pix.pixel_blue};
			col_s1  <= col_q;
			crow_s1 <= XW'(row_q - RW'(1));
			ccol_s1 <= XW'(col_q - CW'(1));
			emit_s1 <= (row_q >= RW'(2)) && (col_q >= CW'(2));
			last_s1 <= row_end && col_end;
		end
	end

	// -----------------------------------------------------------------------
	// Line RAM: {prev row, older row} per column, read on accept,
	// written back one stage later. Same column recurs at least three
	// pixels apart, so no forwarding is needed.
	// -----------------------------------------------------------------------
	logic [2*PW-1:0] ram_rd;
	logic [2*PW-1:0] ram_wd;
	logic            ram_we;

	assign ram_we = s1_go;
	assign ram_wd = {px_s1, ram_rd[2*PW-1:PW]}; // old prev moves down to older

	sed_ram #(
		.WIDTH (2 * PW),
		.DEPTH (MAX_WIDTH)
	) u_line_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (col_s1),
		.wdata (ram_wd),
		.re    (pix_take),
		.raddr (col_q),
		.rdata (ram_rd)
	);

	// -----------------------------------------------------------------------
	// Window and gradients
	// -----------------------------------------------------------------------
	sed_pkg::wcol_t cur;
	sed_pkg::wcol_t win_l_q;
	sed_pkg::wcol_t win_m_q;
	logic signed [GW-1:0] gx [3];
	logic signed [GW-1:0] gy [3];

	assign cur.top = ram_rd[PW-1:0];
	assign cur.mid = ram_rd[2*PW-1:PW];
	assign cur.bot = px_s1;

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			gx[ch] = sed_pkg::grad(cur.top[KW*ch +: KW], cur.mid[KW*ch +: KW],
			                       cur.bot[KW*ch +: KW], win_l_q.top[KW*ch +: KW],
			                       win_l_q.mid[KW*ch +: KW], win_l_q.bot[KW*ch +: KW]);
			gy[ch] = sed_pkg::grad(win_l_q.top[KW*ch +: KW], win_m_q.top[KW*ch +: KW],
			                       cur.top[KW*ch +: KW], win_l_q.bot[KW*ch +: KW],
			                       win_m_q.bot[KW*ch +: KW], cur.bot[KW*ch +: KW]);
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			win_l_q <= win_m_q;
			win_m_q <= cur;
		end
	end

	// -----------------------------------------------------------------------
	// Stage 2 and output register
	// -----------------------------------------------------------------------
	logic signed [GW-1:0] gx_s2 [3];
	logic signed [GW-1:0] gy_s2 [3];
	logic [XW-1:0]        crow_s2;
	logic [XW-1:0]        ccol_s2;
	logic                 last_s2;
	sed_pkg::res_t        res_q;

	always_ff @(posedge clk) begin
		if (s1_go && emit_s1) begin
			for (int ch = 0; ch < 3; ch++) begin
				gx_s2[ch] <= gx[ch];
				gy_s2[ch] <= gy[ch];
			end
			crow_s2 <= crow_s1;
			ccol_s2 <= ccol_s1;
			last_s2 <= last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2 && out_ready) begin
			res_q.edge_red   <= sed_pkg::mag(gx_s2[2], gy_s2[2]);
			res_q.edge_green <= sed_pkg::mag(gx_s2[1], gy_s2[1]);
			res_q.edge_blue  <= sed_pkg::mag(gx_s2[0], gy_s2[0]);
			res_q.centre_row <= crow_s2;
			res_q.centre_col <= ccol_s2;
			res_q.frame_last <= last_s2;
		end
	end

	assign result = res_q;

	// -----------------------------------------------------------------------
	// Checks
	// -----------------------------------------------------------------------
	// write-back never lands on the column being read in the same cycle
	`SED_ASSERT_NEVER(a_ram_same_col, ram_we && pix_take && (col_s1 == col_q))
	// results never come from row 0
	`SED_ASSERT_IMPLY(a_interior_row, result_valid, result.centre_row != '0)

endmodule

[hdl/sed_ram.sv]
// ---------------------------------------------------------------------------
// Sobel edge RAM
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module sed_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
